### src/dpd_pkg.sv
// Shared types and constants for the debug packet deframer.
// No dependencies; imported by every module of the block.
package dpd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned LIMIT_W = 4;
	localparam int unsigned NIB_W   = 4;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h24;
	localparam logic [BYTE_W-1:0] END_MARK   = 8'h23;
	localparam logic [BYTE_W-1:0] ACK_OK     = 8'h2B;
	localparam logic [BYTE_W-1:0] ACK_BAD    = 8'h2D;
	localparam logic [BYTE_W-1:0] ACK_NONE   = 8'h00;
	localparam logic [LEN_W-1:0]  LEN_MAX    = 13'd8191;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_GIVEUP  = 2'd3;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_DIGIT1  = 4'b0100,
		PH_DIGIT2  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] payload;
		logic [BYTE_W-1:0] ack;
		logic [LEN_W-1:0]  length;
	} result_t;

	typedef struct packed {
		logic              bad;
		logic [NIB_W-1:0]  value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
		hex_t h;
		h.bad   = 1'b0;
		h.value = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.value = NIB_W'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.value = NIB_W'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.value = NIB_W'(b - 8'h37);
		end else begin
			h.bad = 1'b1;
		end
		return h;
	endfunction

endpackage

### src/dpd_in_reg.sv
// Input register stage of the debug packet deframer.
// Depends on dpd_pkg for the byte width.
module dpd_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dpd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [dpd_pkg::BYTE_W-1:0] byte_s1
);
	import dpd_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### src/dpd_core.sv
// Framing state machine, checksum and retry count of the debug packet deframer.
// Depends on dpd_pkg for the phase type, result record and hex decoder.
module dpd_core #(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dpd_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                        advance,
	input  logic [dpd_pkg::BYTE_W-1:0]  byte_s1,
	output logic                        has_result,
	output dpd_pkg::result_t            result
);
	import dpd_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD);

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [NIB_W-1:0]   hi_q, hi_d;
	logic               bad_q, bad_d;
	logic [LIMIT_W-1:0] rc_q, rc_d, rc_inc;
	logic [LIMIT_W-1:0] limit_q;
	logic               finish, good;
	hex_t               hex;
	logic [31:0]        cnt_ext;

	assign hex     = hex_decode(byte_s1);
	assign rc_inc  = rc_q + LIMIT_W'(1);
	assign cnt_ext = 32'(cnt_d);

	always_comb begin
		phase_d        = phase_q;
		sum_d          = sum_q;
		cnt_d          = cnt_q;
		hi_d           = hi_q;
		bad_d          = bad_q;
		rc_d           = rc_q;
		finish         = 1'b0;
		good           = 1'b0;
		has_result     = 1'b0;
		result.kind    = KIND_PAYLOAD;
		result.payload = '0;
		result.ack     = ACK_NONE;
		result.length  = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == START_MARK) begin
					phase_d = PH_PAYLOAD;
					sum_d   = '0;
					cnt_d   = '0;
					hi_d    = '0;
					bad_d   = 1'b0;
				end
			end
			PH_PAYLOAD: begin
				if (byte_s1 == END_MARK) begin
					phase_d = PH_DIGIT1;
				end else begin
					sum_d = sum_q + byte_s1;
					cnt_d = cnt_q + CNT_W'(1);
					if (cnt_d == CNT_LIMIT) begin
						finish = 1'b1;
					end else begin
						has_result     = 1'b1;
						result.payload = byte_s1;
					end
				end
			end
			PH_DIGIT1: begin
				phase_d = PH_DIGIT2;
				bad_d   = bad_q | hex.bad;
				hi_d    = hex.bad ? '0 : hex.value;
			end
			PH_DIGIT2: begin
				finish = 1'b1;
				good   = !bad_q && !hex.bad && ({hi_q, hex.value} == sum_q);
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (finish) begin
			has_result    = 1'b1;
			phase_d       = PH_HUNT;
			result.length = (cnt_ext > 32'(LEN_MAX)) ? LEN_MAX : cnt_ext[LEN_W-1:0];
			if (good) begin
				rc_d        = '0;
				result.kind = KIND_ACCEPT;
				result.ack  = ACK_OK;
			end else begin
				result.ack = ACK_BAD;
				if (rc_inc >= limit_q) begin
					rc_d        = '0;
					result.kind = KIND_GIVEUP;
				end else begin
					rc_d        = rc_inc;
					result.kind = KIND_REJECT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			cnt_q   <= '0;
			hi_q    <= '0;
			bad_q   <= 1'b0;
			rc_q    <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			cnt_q   <= cnt_d;
			hi_q    <= hi_d;
			bad_q   <= bad_d;
			rc_q    <= rc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

### src/dpd_out_reg.sv
// Result register of the debug packet deframer.
// Depends on dpd_pkg for the result record and field widths.
module dpd_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  dpd_pkg::result_t           result,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dpd_pkg::KIND_W-1:0] result_kind,
	output logic [dpd_pkg::BYTE_W-1:0] payload_byte,
	output logic [dpd_pkg::BYTE_W-1:0] ack_byte,
	output logic [dpd_pkg::LEN_W-1:0]  packet_length
);
	import dpd_pkg::*;

	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign result_kind   = res_q.kind;
	assign payload_byte  = res_q.payload;
	assign ack_byte      = res_q.ack;
	assign packet_length = res_q.length;

endmodule

### src/debug_packet_deframer_top.sv
// Debug packet deframer: receive side of a remote-debug serial link.
// Channels: in_valid/in_ready carry rx_byte, one received serial byte per
// transaction. out_valid/out_ready carry one result per transaction:
// result_kind, payload_byte, ack_byte and packet_length. Bytes before '$'
// give no result; payload bytes come out one by one; the second checksum
// digit, or an overlong payload, closes the packet with accept, reject or
// give-up. cfg_we/cfg_wdata write the attempt limit (reset value 10).
// Input bytes are registered in the input register, results in the output
// register. Throughput: one byte per cycle unless a result waits on a full
// output, set by the single pass of framing logic between the two registers.
// Reset clears both registers' valid flags, the framing state (hunting for
// '$') and the reject count. When the receiver stalls, the result is held
// and the input register holds one further byte; input ready drops only
// while a byte that needs an output slot is waiting on a full output.
// Depends on dpd_pkg, dpd_in_reg, dpd_core and dpd_out_reg.
module debug_packet_deframer_top #(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dpd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dpd_pkg::KIND_W-1:0]  result_kind,
	output logic [dpd_pkg::BYTE_W-1:0]  payload_byte,
	output logic [dpd_pkg::BYTE_W-1:0]  ack_byte,
	output logic [dpd_pkg::LEN_W-1:0]   packet_length,
	input  logic                        cfg_we,
	input  logic [dpd_pkg::LIMIT_W-1:0] cfg_wdata
);
	import dpd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              has_result;
	result_t           result;

	assign advance = valid_s1 && (!has_result || !out_valid || out_ready);

	dpd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dpd_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.advance    (advance),
		.byte_s1    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	dpd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && has_result),
		.result        (result),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.ack_byte      (ack_byte),
		.packet_length (packet_length)
	);

endmodule

### tb/deframer_check.sv
`timescale 1ns / 1ps
// Result checker for the debug packet deframer: follows the framing state from
// accepted bytes and attempt-limit writes, and compares every delivered result.
// Depends on dpd_pkg for widths, markers, result kinds and the phase encoding.
module deframer_check #(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [dpd_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [dpd_pkg::KIND_W-1:0]   result_kind,
	input  logic [dpd_pkg::BYTE_W-1:0]   payload_byte,
	input  logic [dpd_pkg::BYTE_W-1:0]   ack_byte,
	input  logic [dpd_pkg::LEN_W-1:0]    packet_length,
	input  logic                         cfg_we,
	input  logic [dpd_pkg::LIMIT_W-1:0]  cfg_wdata,
	output int unsigned                  fail_count,
	output int unsigned                  outstanding
);
	import dpd_pkg::*;

	phase_t             framing;
	logic [BYTE_W-1:0]  csum;
	int unsigned        nbytes;
	logic [NIB_W-1:0]   hi_nib;
	logic               bad_nib;
	logic [LIMIT_W-1:0] rejects;
	logic [LIMIT_W-1:0] limit;
	result_t            expected_q[$];
	int unsigned        errs = 0;

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		if (errs < 40) begin
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
		end
		errs++;
	endtask

	// bit 4 set: not a hex digit
	function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b0, c[3:0]};
		end
		if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			return {1'b0, c[3:0] + 4'd9};
		end
		return 5'h10;
	endfunction

	task automatic close_packet(input logic good);
		result_t r;
		r.payload = '0;
		r.length  = (nbytes > LEN_MAX) ? LEN_MAX : LEN_W'(nbytes);
		framing   = PH_HUNT;
		if (good) begin
			rejects = '0;
			r.kind  = KIND_ACCEPT;
			r.ack   = ACK_OK;
		end else begin
			rejects = rejects + 1'b1;
			r.ack   = ACK_BAD;
			if (rejects >= limit) begin
				rejects = '0;
				r.kind  = KIND_GIVEUP;
			end else begin
				r.kind = KIND_REJECT;
			end
		end
		expected_q.push_back(r);
	endtask

	task automatic frame_byte(input logic [BYTE_W-1:0] b);
		result_t    r;
		logic [4:0] nib;
		case (framing)
		PH_HUNT: begin
			if (b == START_MARK) begin
				framing = PH_PAYLOAD;
				csum    = '0;
				nbytes  = 0;
				hi_nib  = '0;
				bad_nib = 1'b0;
			end
		end
		PH_PAYLOAD: begin
			if (b == END_MARK) begin
				framing = PH_DIGIT1;
			end else begin
				csum = csum + b;
				nbytes++;
				if (nbytes >= MAX_PAYLOAD) begin
					close_packet(1'b0);
				end else begin
					r.kind    = KIND_PAYLOAD;
					r.payload = b;
					r.ack     = ACK_NONE;
					r.length  = '0;
					expected_q.push_back(r);
				end
			end
		end
		PH_DIGIT1: begin
			nib = nibble_of(b);
			if (nib[4]) begin
				bad_nib = 1'b1;
				hi_nib  = '0;
			end else begin
				hi_nib = nib[3:0];
			end
			framing = PH_DIGIT2;
		end
		default: begin
			nib = nibble_of(b);
			if (bad_nib || nib[4]) begin
				close_packet(1'b0);
			end else begin
				close_packet({hi_nib, nib[3:0]} == csum);
			end
		end
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (expected_q.size() == 0) begin
			report("unexpected result, kind", 16'(result_kind), 16'hffff);
			return;
		end
		want = expected_q.pop_front();
		if (result_kind !== want.kind) begin
			report("result_kind", 16'(result_kind), 16'(want.kind));
		end
		if (payload_byte !== want.payload) begin
			report("payload_byte", 16'(payload_byte), 16'(want.payload));
		end
		if (ack_byte !== want.ack) begin
			report("ack_byte", 16'(ack_byte), 16'(want.ack));
		end
		if (packet_length !== want.length) begin
			report("packet_length", 16'(packet_length), 16'(want.length));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing = PH_HUNT;
			csum    = '0;
			nbytes  = 0;
			hi_nib  = '0;
			bad_nib = 1'b0;
			rejects = '0;
			limit   = LIMIT_RESET;
			expected_q.delete();
			outstanding <= 0;
			fail_count  <= errs;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
			end
			if (cfg_we) begin
				limit = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				frame_byte(rx_byte);
			end
			outstanding <= expected_q.size();
			fail_count  <= errs;
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Deframer testbench top: clock, reset, serial byte stimulus, receiver stalls
// and the verdict. Depends on dpd_pkg, debug_packet_deframer_top and deframer_check.
module tb;
	import dpd_pkg::*;

	localparam int unsigned PAYLOAD_CAP = 4096;
	localparam int unsigned PHASE_BYTES = 125;
	localparam int unsigned NUM_PHASES  = 8;

	typedef enum {TAIL_GOOD, TAIL_WRONG, TAIL_BAD_HIGH, TAIL_BAD_LOW, TAIL_NONE} tail_t;
	typedef enum {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC} rx_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   result_kind;
	logic [BYTE_W-1:0]   payload_byte;
	logic [BYTE_W-1:0]   ack_byte;
	logic [LEN_W-1:0]    packet_length;
	logic                cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;
	int unsigned         fail_count;
	int unsigned         outstanding;

	int                  burst_left = 0;
	rx_mode_t            rx_mode    = RX_OPEN;
	int                  rx_hold    = 0;

	logic [BYTE_W-1:0] opening [0:30] = '{
		8'hFF, END_MARK,
		START_MARK, 8'h00, 8'hFF, START_MARK, END_MARK, 8'h32, 8'h33,
		START_MARK, END_MARK, 8'h30, 8'h30,
		START_MARK, 8'hFF, END_MARK, 8'h66, 8'h46,
		START_MARK, 8'h01, END_MARK, 8'h30, 8'h32,
		START_MARK, END_MARK, 8'h67, 8'h30,
		START_MARK, END_MARK, 8'h30, 8'h47
	};

	logic [LIMIT_W-1:0] limits [0:NUM_PHASES-1] = '{
		4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd1, 4'd6, 4'd10
	};

	debug_packet_deframer_top #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.payload_byte(payload_byte),
		.ack_byte(ack_byte),
		.packet_length(packet_length),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	deframer_check #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.payload_byte(payload_byte),
		.ack_byte(ack_byte),
		.packet_length(packet_length),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(16, 256);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_mode)
		RX_OPEN:     out_ready <= 1'b1;
		RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
		RX_CHOKED:   out_ready <= ($urandom_range(0, 7) == 0);
		default:     out_ready <= (rx_hold % 5 != 0);
		endcase
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold the sender until every result is out and the pipeline is empty
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + n;
		end
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	task automatic send_packet(input int unsigned len, input tail_t tail, input bit raw);
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sum;
		int unsigned       i;
		sum = '0;
		send_byte(START_MARK);
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (!raw && b == END_MARK) begin
				b = 8'h22;
			end
			sum = sum + b;
			send_byte(b);
		end
		if (tail == TAIL_NONE) begin
			return;
		end
		send_byte(END_MARK);
		if (tail == TAIL_WRONG) begin
			sum = sum + 8'($urandom_range(1, 255));
		end
		send_byte(tail == TAIL_BAD_HIGH ? 8'($urandom) : hex_char(sum[7:4]));
		send_byte(tail == TAIL_BAD_LOW ? 8'($urandom) : hex_char(sum[3:0]));
	endtask

	task automatic send_random_frame(output int unsigned used);
		int          sel;
		int unsigned len;
		tail_t       tail;
		sel = $urandom_range(0, 99);
		used = 0;
		if (sel < 6) begin
			len = $urandom_range(1, 4);
			repeat (len) send_byte(8'($urandom));
			return;
		end
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
		if (sel < 70) begin
			tail = TAIL_GOOD;
		end else if (sel < 82) begin
			tail = TAIL_WRONG;
		end else if (sel < 91) begin
			tail = TAIL_BAD_HIGH;
		end else begin
			tail = TAIL_BAD_LOW;
		end
		send_packet(len, tail, sel < 14);
		used = len + 4;
	endtask

	initial begin
		int unsigned done;
		int unsigned used;
		int          ph;
		int          i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 31; i++) begin
			send_byte(opening[i]);
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_limit(ph == 6 ? 4'($urandom_range(1, 15)) : limits[ph]);
			if (ph == 5) begin
				send_packet(PAYLOAD_CAP, TAIL_NONE, 1'b0);
			end
			done = 0;
			while (done < PHASE_BYTES) begin
				send_random_frame(used);
				done += used;
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
